// File: design/hcg_pkg.sv
// Shared constants and codes for the Hankel column generator.
package hcg_pkg;

   // Field widths
   localparam int COORD_BITS      = 16;
   localparam int WINDOW_BITS     = 6;
   localparam int ROW_BITS        = 6;
   localparam int COL_BITS        = 16;
   localparam int SEEN_BITS       = 17;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 6;

   // Limits and defaults
   localparam int DEFAULT_MAX_WINDOW = 32;
   localparam logic [SEEN_BITS-1:0]   SEEN_MAX      = '1;
   localparam logic [COL_BITS-1:0]    COL_MAX       = '1;
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET  = 6'd8;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LAYOUT_MODE   = 2'd1;

   // Row order codes
   localparam logic LAYOUT_INTERLEAVED = 1'b0;
   localparam logic LAYOUT_STACKED     = 1'b1;

endpackage

// File: design/hcg_req_if.sv
// Point channel: one trajectory point per beat.
interface hcg_req_if;
   import hcg_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] x_coord;
   logic [COORD_BITS-1:0] y_coord;
   logic                  starts_track;

   modport source (output valid, output x_coord, output y_coord, output starts_track,
                   input ready);
   modport sink   (input valid, input x_coord, input y_coord, input starts_track,
                   output ready);
endinterface

// File: design/hcg_rsp_if.sv
// Matrix entry channel: one Hankel matrix entry per beat.
interface hcg_rsp_if;
   import hcg_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] element;
   logic [ROW_BITS-1:0]   row_index;
   logic [COL_BITS-1:0]   column_index;
   logic                  column_end;

   modport source (output valid, output element, output row_index, output column_index,
                   output column_end, input ready);
   modport sink   (input valid, input element, input row_index, input column_index,
                   input column_end, output ready);
endinterface

// File: design/hcg_window_ram.sv
// Circular point store: one write port, one read port, registered read data.
module hcg_window_ram #(
   parameter int DEPTH     = hcg_pkg::DEFAULT_MAX_WINDOW,
   parameter int ADDR_BITS = 5,
   parameter int DATA_BITS = 2 * hcg_pkg::COORD_BITS
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);
   import hcg_pkg::*;

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/hankel_column_generator.sv
// Hankel column generator: top level with point store, sequencer and output stage.
// Points (x, y) are written into a circular store of MAX_WINDOW entries held in a
// one-port-read synchronous memory. Once window_length points of the current track
// have arrived (starts_track restarts the count), each point produces one column of
// 2*W entries (W = window_length clamped to 1..MAX_WINDOW), oldest point first, in
// interleaved (x0,y0,x1,y1,...) or stacked (all x, then all y) order per layout_mode.
// Entries leave one per beat. While a point that yields a column is stored and its
// entries are read, one memory read per entry and held while the output stage is
// stalled, no new point is taken; the store's single read port sets this pace.
// The store needs no clearing after reset; configuration is taken between points.
module hankel_column_generator #(
   parameter int MAX_WINDOW = hcg_pkg::DEFAULT_MAX_WINDOW
) (
   input  logic                                clock,
   input  logic                                reset,
   hcg_req_if.sink                             req_bus,
   hcg_rsp_if.source                           rsp_bus,
   input  logic                                csr_write_en,
   input  logic [hcg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [hcg_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);
   import hcg_pkg::*;

   localparam int IDX_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int ENTRY_BITS = 2 * COORD_BITS;
   localparam int SUM_BITS  = WINDOW_BITS + 1;
   localparam logic [WINDOW_BITS-1:0] MAX_W     = WINDOW_BITS'(MAX_WINDOW);
   localparam logic [IDX_BITS-1:0]    LAST_SLOT = IDX_BITS'(MAX_WINDOW - 1);
   localparam logic [SUM_BITS-1:0]    DEPTH_S   = SUM_BITS'(MAX_WINDOW);

   typedef enum logic {ST_IDLE, ST_EMIT} state_type;

   // Registers
   state_type              state_ff,      state_in;
   logic [IDX_BITS-1:0]    wp_ff,         wp_in;
   logic [SEEN_BITS-1:0]   seen_ff,       seen_in;
   logic [WINDOW_BITS-1:0] win_len_ff,    win_len_in;
   logic                   layout_ff,     layout_in;
   logic                   mode_ff,       mode_in;
   logic [WINDOW_BITS-1:0] w_ff,          w_in;
   logic [IDX_BITS-1:0]    oldest_ff,     oldest_in;
   logic [IDX_BITS-1:0]    slot_ff,       slot_in;
   logic [ROW_BITS-1:0]    row_ff,        row_in;
   logic [ROW_BITS-1:0]    last_row_ff,   last_row_in;
   logic [COL_BITS-1:0]    col_ff,        col_in;
   logic                   out_valid_ff,  out_valid_in;
   logic [ROW_BITS-1:0]    out_row_ff,    out_row_in;
   logic [COL_BITS-1:0]    out_col_ff,    out_col_in;
   logic                   out_end_ff,    out_end_in;
   logic                   out_take_x_ff, out_take_x_in;

   // Combinational helpers
   logic                   accept;
   logic                   issue;
   logic                   take_x;
   logic                   at_last;
   logic [IDX_BITS-1:0]    slot_inc;
   logic [IDX_BITS-1:0]    wp_next;
   logic [WINDOW_BITS-1:0] eff_w;
   logic [SEEN_BITS-1:0]   seen_base;
   logic [SEEN_BITS-1:0]   seen_next;
   logic [SEEN_BITS-1:0]   col_wide;
   logic [SUM_BITS-1:0]    oldest_sum;
   logic [SUM_BITS-1:0]    oldest_mod;
   logic [SUM_BITS-1:0]    rows_m1;
   logic                   has_col;
   logic [ENTRY_BITS-1:0]  rd_data;

   assign accept = req_bus.valid && req_bus.ready;
   assign issue  = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_bus.ready);

   // Point store
   hcg_window_ram #(
      .DEPTH     (MAX_WINDOW),
      .ADDR_BITS (IDX_BITS),
      .DATA_BITS (ENTRY_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wp_ff),
      .wr_data ({req_bus.x_coord, req_bus.y_coord}),
      .rd_en   (issue),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   // Per-point bookkeeping
   always_comb begin
      wp_next = (wp_ff == LAST_SLOT) ? '0 : wp_ff + 1'b1;

      if (win_len_ff == '0) begin
         eff_w = WINDOW_BITS'(1);
      end else if (win_len_ff > MAX_W) begin
         eff_w = MAX_W;
      end else begin
         eff_w = win_len_ff;
      end

      seen_base = req_bus.starts_track ? '0 : seen_ff;
      seen_next = (seen_base == SEEN_MAX) ? seen_base : seen_base + 1'b1;
      has_col   = seen_next >= SEEN_BITS'(eff_w);
      col_wide  = seen_next - SEEN_BITS'(eff_w);

      // oldest slot of the window = (wp_next - W) mod depth
      oldest_sum = SUM_BITS'(wp_next) + DEPTH_S - SUM_BITS'(eff_w);
      oldest_mod = (oldest_sum >= DEPTH_S) ? oldest_sum - DEPTH_S : oldest_sum;
      rows_m1    = {eff_w, 1'b0} - SUM_BITS'(1);
   end

   // Row sequencing
   always_comb begin
      slot_inc = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
      at_last  = (row_ff == last_row_ff);
      if (mode_ff == LAYOUT_INTERLEAVED) begin
         take_x = ~row_ff[0];
      end else begin
         take_x = row_ff < w_ff;
      end
   end

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      seen_in       = seen_ff;
      win_len_in    = win_len_ff;
      layout_in     = layout_ff;
      mode_in       = mode_ff;
      w_in          = w_ff;
      oldest_in     = oldest_ff;
      slot_in       = slot_ff;
      row_in        = row_ff;
      last_row_in   = last_row_ff;
      col_in        = col_ff;
      out_valid_in  = out_valid_ff;
      out_row_in    = out_row_ff;
      out_col_in    = out_col_ff;
      out_end_in    = out_end_ff;
      out_take_x_in = out_take_x_ff;

      // configuration writes
      if (csr_write_en) begin
         unique case (csr_index)
            REG_WINDOW_LENGTH: win_len_in = csr_write_data;
            REG_LAYOUT_MODE:   layout_in  = csr_write_data[0];
            default:           ;
         endcase
      end

      // output stage drains
      if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wp_in   = wp_next;
               seen_in = seen_next;
               if (has_col) begin
                  state_in    = ST_EMIT;
                  mode_in     = layout_ff;
                  w_in        = eff_w;
                  oldest_in   = oldest_mod[IDX_BITS-1:0];
                  slot_in     = oldest_mod[IDX_BITS-1:0];
                  row_in      = '0;
                  last_row_in = rows_m1[ROW_BITS-1:0];
                  col_in      = (col_wide > SEEN_BITS'(COL_MAX)) ? COL_MAX
                                                                 : col_wide[COL_BITS-1:0];
               end
            end
         end
         ST_EMIT: begin
            if (issue) begin
               out_valid_in  = 1'b1;
               out_row_in    = row_ff;
               out_col_in    = col_ff;
               out_end_in    = at_last;
               out_take_x_in = take_x;
               row_in        = row_ff + 1'b1;
               if (mode_ff == LAYOUT_INTERLEAVED) begin
                  slot_in = row_ff[0] ? slot_inc : slot_ff;
               end else begin
                  slot_in = (row_ff == w_ff - 1'b1) ? oldest_ff : slot_inc;
               end
               if (at_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         seen_ff      <= '0;
         win_len_ff   <= WINDOW_RESET;
         layout_ff    <= LAYOUT_INTERLEAVED;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         seen_ff      <= seen_in;
         win_len_ff   <= win_len_in;
         layout_ff    <= layout_in;
         out_valid_ff <= out_valid_in;
      end
      mode_ff       <= mode_in;
      w_ff          <= w_in;
      oldest_ff     <= oldest_in;
      slot_ff       <= slot_in;
      row_ff        <= row_in;
      last_row_ff   <= last_row_in;
      col_ff        <= col_in;
      out_row_ff    <= out_row_in;
      out_col_ff    <= out_col_in;
      out_end_ff    <= out_end_in;
      out_take_x_ff <= out_take_x_in;
   end

   // Ports
   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.element      = out_take_x_ff ? rd_data[ENTRY_BITS-1:COORD_BITS]
                                               : rd_data[COORD_BITS-1:0];
   assign rsp_bus.row_index    = out_row_ff;
   assign rsp_bus.column_index = out_col_ff;
   assign rsp_bus.column_end   = out_end_ff;

endmodule

// File: tb/tb_hankel_column_generator.sv
// Self-checking testbench for the Hankel column generator: point stimulus, column prediction, entry checks.
module tb_hankel_column_generator;
   timeunit 1ns;
   timeprecision 1ps;

   import hcg_pkg::*;

   localparam int MAX_W             = DEFAULT_MAX_WINDOW;
   localparam int SETTLE_CYCLES     = 2 * MAX_W + 8;
   localparam int QUIET_LIMIT       = 2000;
   localparam int RANDOM_POINTS     = 380;
   localparam int REPORT_CAP        = 30;

   typedef struct packed {
      logic [COORD_BITS-1:0] x_coord;
      logic [COORD_BITS-1:0] y_coord;
      logic                  starts_track;
   } track_point_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] element;
      logic [ROW_BITS-1:0]   row_index;
      logic [COL_BITS-1:0]   column_index;
      logic                  column_end;
   } hankel_entry_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   hcg_req_if req_bus();
   hcg_rsp_if rsp_bus();

   hankel_column_generator dut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // Predictor state: point history, track count and register copies
   logic [COORD_BITS-1:0] x_history [MAX_W];
   logic [COORD_BITS-1:0] y_history [MAX_W];
   int unsigned           next_slot = 0;
   logic [SEEN_BITS-1:0]  track_points = '0;
   logic [WINDOW_BITS-1:0] window_copy = WINDOW_RESET;
   logic                  layout_copy = LAYOUT_INTERLEAVED;

   track_point_type  pending_points [$];
   hankel_entry_type entries_due [$];

   // Handshake flags, set at the rising edge and read at the falling edge
   bit point_taken;
   bit entry_taken;
   bit steady_flow;
   int unsigned gap_left;
   int unsigned stall_left;
   int unsigned quiet_cycles;

   int unsigned mismatches;
   int unsigned points_accepted;
   int unsigned entries_checked;
   int unsigned tracks_started;
   int unsigned columns_predicted;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned effective_window(input logic [WINDOW_BITS-1:0] setting);
      if (setting == 0) return 1;
      if (setting > MAX_W) return MAX_W;
      return int'(setting);
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [COORD_BITS-1:0] random_coord();
      case ($urandom_range(0, 15))
         0: return {1'b1, {(COORD_BITS-1){1'b0}}};
         1: return {1'b0, {(COORD_BITS-1){1'b1}}};
         2: return '0;
         3: return '1;
         default: return COORD_BITS'($urandom);
      endcase
   endfunction

   // Store the point and queue the column it completes, if any
   function automatic void predict_column(input track_point_type pt);
      int unsigned w;
      int unsigned col;
      int unsigned oldest;
      int unsigned k;
      logic take_x;
      hankel_entry_type ent;
      if (pt.starts_track) track_points = '0;
      x_history[next_slot] = pt.x_coord;
      y_history[next_slot] = pt.y_coord;
      next_slot = (next_slot + 1) % MAX_W;
      if (track_points != SEEN_MAX) track_points = track_points + 1'b1;
      w = effective_window(window_copy);
      if (track_points < w) return;
      col = track_points - w;
      if (col > COL_MAX) col = COL_MAX;
      oldest = (next_slot + MAX_W - w) % MAX_W;
      for (int unsigned r = 0; r < 2 * w; r++) begin
         if (layout_copy == LAYOUT_INTERLEAVED) begin
            k = r / 2;
            take_x = (r % 2) == 0;
         end else begin
            take_x = r < w;
            k = take_x ? r : r - w;
         end
         ent.element      = take_x ? x_history[(oldest + k) % MAX_W]
                                   : y_history[(oldest + k) % MAX_W];
         ent.row_index    = ROW_BITS'(r);
         ent.column_index = COL_BITS'(col);
         ent.column_end   = (r + 1 == 2 * w);
         entries_due.push_back(ent);
      end
      columns_predicted++;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      if (mismatches < REPORT_CAP)
         $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   // Rising edge: check entry beats, predict on point beats, watchdog
   always @(posedge clock) begin : watch_beats
      hankel_entry_type want;
      point_taken = req_bus.valid && req_bus.ready && !reset;
      entry_taken = rsp_bus.valid && rsp_bus.ready && !reset;
      if (entry_taken) begin
         entries_checked++;
         if (entries_due.size() == 0) begin
            report_mismatch("entry with no column pending", rsp_bus.element, 0);
         end else begin
            want = entries_due.pop_front();
            if (rsp_bus.element !== want.element)
               report_mismatch("element", rsp_bus.element, want.element);
            if (rsp_bus.row_index !== want.row_index)
               report_mismatch("row_index", rsp_bus.row_index, want.row_index);
            if (rsp_bus.column_index !== want.column_index)
               report_mismatch("column_index", rsp_bus.column_index, want.column_index);
            if (rsp_bus.column_end !== want.column_end)
               report_mismatch("column_end", rsp_bus.column_end, want.column_end);
         end
      end
      if (point_taken) begin
         points_accepted++;
         predict_column('{req_bus.x_coord, req_bus.y_coord, req_bus.starts_track});
      end
      if (reset || point_taken || entry_taken) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d entries outstanding",
                     quiet_cycles, entries_due.size());
            $display("tb_hankel_column_generator: FAIL");
            $finish;
         end
      end
   end

   // Point driver: next point after a taken beat, with random gaps
   always @(negedge clock) begin : drive_points
      track_point_type pt;
      if (!reset && (!req_bus.valid || point_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_points.size() > 0) begin
            pt = pending_points.pop_front();
            req_bus.valid        <= 1'b1;
            req_bus.x_coord      <= pt.x_coord;
            req_bus.y_coord      <= pt.y_coord;
            req_bus.starts_track <= pt.starts_track;
            gap_left = steady_flow ? 0 : pick_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Entry sink: stalls start after beats or at random while idle
   always @(negedge clock) begin
      if (!reset) begin
         if (!steady_flow && stall_left == 0 && (entry_taken || $urandom_range(0, 15) == 0))
            stall_left = pick_gap();
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(posedge clock);
      if (idx == REG_WINDOW_LENGTH) window_copy = value;
      else if (idx == REG_LAYOUT_MODE) layout_copy = value[0];
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic push_point(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                             input logic first);
      while (pending_points.size() >= 8) @(posedge clock);
      pending_points.push_back('{x, y, first});
      if (first) tracks_started++;
   endtask

   // Hold off until all points are taken and every column has come out
   task automatic drain_and_settle();
      while (pending_points.size() != 0 || req_bus.valid) @(posedge clock);
      while (entries_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [WINDOW_BITS-1:0] window, input logic layout);
      drain_and_settle();
      write_register(REG_WINDOW_LENGTH, window);
      write_register(REG_LAYOUT_MODE, CSR_DATA_BITS'(layout));
   endtask

   initial begin : stimulus
      int unsigned random_sent;
      int unsigned budget;
      int unsigned sent;
      int unsigned w;
      int unsigned len;
      int unsigned phase;
      logic [WINDOW_BITS-1:0] window;
      bit fresh;

      reset                = 1'b1;
      csr_write_en         = 1'b0;
      csr_index            = '0;
      csr_write_data       = '0;
      req_bus.valid        = 1'b0;
      req_bus.x_coord      = '0;
      req_bus.y_coord      = '0;
      req_bus.starts_track = 1'b0;
      rsp_bus.ready        = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: coordinate extremes, window 2, interleaved rows
      configure(2, LAYOUT_INTERLEAVED);
      push_point(16'h8000, 16'h7FFF, 1'b1);
      push_point(16'h7FFF, 16'h8000, 1'b0);
      push_point(16'hFFFF, 16'h0000, 1'b0);
      push_point(16'h0000, 16'hFFFF, 1'b0);
      push_point(16'h5555, 16'hAAAA, 1'b0);
      // New track: first point alone is too short for a column
      push_point(16'h1234, 16'hEDCB, 1'b1);
      push_point(16'h0F0F, 16'hF0F0, 1'b0);
      // Window grows mid-track, stacked rows
      configure(3, LAYOUT_STACKED);
      push_point(16'h4001, 16'hBFFE, 1'b0);
      push_point(16'h0001, 16'hFFFE, 1'b0);
      // Window zero behaves as one
      configure(0, LAYOUT_INTERLEAVED);
      push_point(16'h7FFF, 16'h7FFF, 1'b1);
      push_point(16'h8000, 16'h8000, 1'b0);
      // Window above the maximum clamps; short track gives nothing
      configure(63, LAYOUT_STACKED);
      push_point(16'h0101, 16'h0202, 1'b0);
      push_point(16'h0303, 16'h0404, 1'b1);
      push_point(16'h0505, 16'h0606, 1'b0);
      configure(8, LAYOUT_INTERLEAVED);

      // Random phases: mostly whole tracks, some short ones and stray restarts
      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_POINTS) begin
         case ($urandom_range(0, 9))
            0: window = WINDOW_BITS'(0);
            1: window = WINDOW_BITS'(1);
            2: window = WINDOW_BITS'(MAX_W);
            3: window = '1;
            4: window = WINDOW_BITS'($urandom_range(MAX_W + 1, 62));
            default: window = WINDOW_BITS'($urandom_range(1, 12));
         endcase
         configure(window, 1'($urandom_range(0, 1)));
         steady_flow = ($urandom_range(0, 3) == 0);
         w = effective_window(window);
         budget = $urandom_range(20, 45);
         sent = 0;
         fresh = ($urandom_range(0, 2) != 0);
         while (sent < budget) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w) : w + $urandom_range(0, 8);
            for (int unsigned i = 0; i < len; i++)
               push_point(random_coord(), random_coord(),
                          (i == 0) ? fresh : ($urandom_range(0, 29) == 0));
            sent += len;
            fresh = 1'b1;
            // Sender waits for every pending entry once in a while
            if (phase % 4 == 1 && sent < budget) drain_and_settle();
         end
         random_sent += sent;
         phase++;
      end

      steady_flow = 1'b0;
      drain_and_settle();
      $display("Run covered %0d points in %0d tracks, %0d columns and %0d entries checked,",
               points_accepted, tracks_started, columns_predicted, entries_checked);
      $display("windows 0 to 63 in both row orders, with short tracks and mid-track restarts.");
      if (mismatches == 0) begin
         $display("tb_hankel_column_generator: PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb_hankel_column_generator: FAIL");
      end
      $finish;
   end

endmodule

// File: hankel_column_generator.f
design/hcg_pkg.sv
design/hcg_req_if.sv
design/hcg_rsp_if.sv
design/hcg_window_ram.sv
design/hankel_column_generator.sv
tb/tb_hankel_column_generator.sv
